@@ src/svrhd_pkg.sv @@
package svrhd_pkg;

	localparam int POS_AW = 12;
	localparam int SYM_AW = 8;
	localparam int LEN_SLOTS = 32;

	localparam logic [15:0] MAX_ENTRIES = 16'd4096;
	localparam logic [10:0] QUOTIENT_CAP = 11'd2000;
	localparam logic [7:0] SYMBOL_BIAS = 8'h80;
	localparam logic [5:0] COUNT_BITS = 6'd16;
	localparam logic [5:0] SYMBOL_BITS = 6'd8;
	localparam logic [5:0] LENGTH_BITS = 6'd5;
	localparam logic [5:0] RICE_BITS = 6'd3;
	localparam logic [5:0] FIRST_POS_BITS = 6'd11;
	localparam logic [5:0] MAX_CODE_LENGTH = 6'd32;

	localparam logic [1:0] KIND_VALUE = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [2:0] ERR_NONE = 3'd0;
	localparam logic [2:0] ERR_TRUNCATED = 3'd1;
	localparam logic [2:0] ERR_EMPTY_ALPHABET = 3'd2;
	localparam logic [2:0] ERR_TOO_MANY = 3'd3;
	localparam logic [2:0] ERR_RICE_RUNAWAY = 3'd4;
	localparam logic [2:0] ERR_POS_RANGE = 3'd5;
	localparam logic [2:0] ERR_BAD_CODE = 3'd6;

	typedef enum logic [3:0] {
		PH_COUNT, PH_MIN, PH_MAX, PH_PRESENT, PH_LENGTHS, PH_RICE,
		PH_FIRST, PH_UNARY, PH_REMAINDER, PH_VALUES, PH_IDLE
	} phase_t;

	typedef enum logic [3:0] {
		SQ_WAIT, SQ_BIT, SQ_NEXT, SQ_FC, SQ_SORT_RD, SQ_SORT_WR,
		SQ_VAL_EMIT, SQ_VAL_DONE, SQ_END, SQ_FLUSH
	} seq_t;

	typedef struct packed {
		logic [15:0] position;
		logic [7:0]  value;
		logic [1:0]  kind;
		logic [2:0]  err;
		logic        last;
	} result_t;

endpackage

@@ src/svrhd_ram.sv @@
module svrhd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/svrhd_core.sv @@
module svrhd_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          stream_byte,
	input  logic                final_byte,
	input  logic [15:0]         dim_limit,
	input  logic                out_free,
	output logic                res_push,
	output svrhd_pkg::result_t  res
);

	svrhd_pkg::seq_t    seq_q, seq_d;
	svrhd_pkg::phase_t  phase_q, phase_d;
	logic [2:0]         bit_idx_q, bit_idx_d;
	logic [7:0]         byte_q, byte_d;
	logic               final_q, final_d;
	logic [5:0]         field_cnt_q, field_cnt_d;
	logic [31:0]        field_q, field_d;
	logic [15:0]        total_q, total_d;
	logic [7:0]         min_q, min_d;
	logic [7:0]         max_q, max_d;
	logic [8:0]         asize_q, asize_d;
	logic [12:0]        item_q, item_d;
	logic [2:0]         rice_q, rice_d;
	logic [15:0]        cur_q, cur_d;
	logic [10:0]        quot_q, quot_d;
	logic [31:0]        acc_q, acc_d;
	logic [5:0]         clen_q, clen_d;
	logic [4:0]         tlen_q, tlen_d;
	logic [31:0]        tnext_q, tnext_d;
	logic [8:0]         tbase_q, tbase_d;
	logic [8:0]         sort_i_q, sort_i_d;
	logic               pend_valid_q, pend_valid_d;
	svrhd_pkg::result_t pend_q, pend_d;

	logic [8:0]  lcount_q [svrhd_pkg::LEN_SLOTS];
	logic [8:0]  lcount_d [svrhd_pkg::LEN_SLOTS];
	logic [31:0] fcode_q [svrhd_pkg::LEN_SLOTS];
	logic [31:0] fcode_d [svrhd_pkg::LEN_SLOTS];
	logic [8:0]  base_q [svrhd_pkg::LEN_SLOTS];
	logic [8:0]  base_d [svrhd_pkg::LEN_SLOTS];
	logic [8:0]  fill_q [svrhd_pkg::LEN_SLOTS];
	logic [8:0]  fill_d [svrhd_pkg::LEN_SLOTS];

	// ram ports
	logic                        alpha_we, alpha_re, len_we, sorted_we, sorted_re;
	logic                        pos_we, pos_re;
	logic [svrhd_pkg::SYM_AW-1:0] alpha_waddr, len_waddr, sort_raddr;
	logic [svrhd_pkg::SYM_AW-1:0] sorted_waddr, sorted_raddr;
	logic [7:0]                  alpha_wdata, alpha_rdata, sorted_rdata;
	logic [4:0]                  len_rdata;
	logic [svrhd_pkg::POS_AW-1:0] pos_waddr, pos_raddr;
	logic [15:0]                 pos_wdata, pos_rdata;

	// per-bit datapath
	logic        bit_in;
	logic [31:0] nfield;
	logic [5:0]  ncnt;
	logic [7:0]  lo_b, hi_b, span;
	logic        present_end;
	logic [8:0]  asize_new;
	logic [12:0] item_inc;
	logic [4:0]  len_new;
	logic        first_done, first_bad;
	logic [10:0] quot_inc;
	logic [6:0]  rem;
	logic [31:0] gap_step, gap_next;
	logic        gap_finish, gap_bad;
	logic [5:0]  nlen;
	logic [31:0] nacc, code_off;
	logic [4:0]  tbl_idx;
	logic [8:0]  lc_sel, base_sel, fill_sel;
	logic [31:0] fc_sel;
	logic        code_hit;
	logic [8:0]  code_idx;

	// event of this cycle
	logic        ev_emit, go;
	svrhd_pkg::result_t ev_res;

	assign bit_in = byte_q[bit_idx_q];
	assign nfield = {field_q[30:0], bit_in};
	assign ncnt = field_cnt_q + 6'd1;
	assign lo_b = min_q ^ svrhd_pkg::SYMBOL_BIAS;
	assign hi_b = max_q ^ svrhd_pkg::SYMBOL_BIAS;
	assign span = hi_b - lo_b;
	assign present_end = item_q >= {5'd0, span};
	assign asize_new = asize_q + {8'd0, bit_in};
	assign item_inc = item_q + 13'd1;
	assign len_new = nfield[4:0];
	assign first_done = ncnt >= svrhd_pkg::FIRST_POS_BITS;
	assign first_bad = {5'd0, nfield[10:0]} >= dim_limit;
	assign quot_inc = quot_q + 11'd1;
	assign rem = (phase_q == svrhd_pkg::PH_REMAINDER) ? nfield[6:0] : 7'd0;
	assign gap_step = ({21'd0, quot_q} << rice_q) | {25'd0, rem};
	assign gap_next = {16'd0, cur_q} + gap_step + 32'd1;
	assign gap_bad = gap_next >= {16'd0, dim_limit};
	assign gap_finish = ((phase_q == svrhd_pkg::PH_UNARY) && !bit_in && rice_q == 3'd0)
		|| ((phase_q == svrhd_pkg::PH_REMAINDER) && ncnt >= {3'd0, rice_q});
	assign nlen = clen_q + 6'd1;
	assign nacc = {acc_q[30:0], bit_in};

	// one shared read index into the per-length tables
	always_comb begin
		case (seq_q)
			svrhd_pkg::SQ_FC:      tbl_idx = tlen_q;
			svrhd_pkg::SQ_SORT_WR: tbl_idx = len_rdata;
			default:               tbl_idx = (phase_q == svrhd_pkg::PH_LENGTHS) ? len_new
				: nlen[4:0];
		endcase
	end

	assign lc_sel = lcount_q[tbl_idx];
	assign fc_sel = fcode_q[tbl_idx];
	assign base_sel = base_q[tbl_idx];
	assign fill_sel = fill_q[tbl_idx];
	assign code_off = nacc - fc_sel;
	assign code_hit = !nlen[5] && lc_sel != 9'd0 && code_off < {23'd0, lc_sel};
	assign code_idx = base_sel + code_off[8:0];

	// result raised by this cycle, if any
	always_comb begin
		ev_emit = 1'b0;
		ev_res = '0;
		ev_res.kind = svrhd_pkg::KIND_ERROR;
		case (seq_q)
			svrhd_pkg::SQ_BIT: begin
				case (phase_q)
					svrhd_pkg::PH_COUNT: begin
						if (ncnt >= svrhd_pkg::COUNT_BITS
							&& nfield[15:0] > svrhd_pkg::MAX_ENTRIES) begin
							ev_emit = 1'b1;
							ev_res.err = svrhd_pkg::ERR_TOO_MANY;
						end
					end
					svrhd_pkg::PH_MAX: begin
						if (ncnt >= svrhd_pkg::SYMBOL_BITS) begin
							if (total_q == 16'd0) begin
								ev_emit = 1'b1;
								ev_res.kind = svrhd_pkg::KIND_DONE;
							end else if (nfield[7:0] < lo_b) begin
								ev_emit = 1'b1;
								ev_res.err = svrhd_pkg::ERR_EMPTY_ALPHABET;
							end
						end
					end
					svrhd_pkg::PH_PRESENT: begin
						if (present_end && asize_new == 9'd0) begin
							ev_emit = 1'b1;
							ev_res.err = svrhd_pkg::ERR_EMPTY_ALPHABET;
						end
					end
					svrhd_pkg::PH_FIRST: begin
						if (first_done && first_bad) begin
							ev_emit = 1'b1;
							ev_res.err = svrhd_pkg::ERR_POS_RANGE;
						end
					end
					svrhd_pkg::PH_UNARY, svrhd_pkg::PH_REMAINDER: begin
						if (phase_q == svrhd_pkg::PH_UNARY && bit_in) begin
							if (quot_inc > svrhd_pkg::QUOTIENT_CAP) begin
								ev_emit = 1'b1;
								ev_res.err = svrhd_pkg::ERR_RICE_RUNAWAY;
							end
						end else if (gap_finish && gap_bad) begin
							ev_emit = 1'b1;
							ev_res.err = svrhd_pkg::ERR_POS_RANGE;
						end
					end
					svrhd_pkg::PH_VALUES: begin
						if (!code_hit && nlen >= svrhd_pkg::MAX_CODE_LENGTH) begin
							ev_emit = 1'b1;
							ev_res.err = svrhd_pkg::ERR_BAD_CODE;
						end
					end
					default: ;
				endcase
			end
			svrhd_pkg::SQ_VAL_EMIT: begin
				ev_emit = 1'b1;
				ev_res.kind = svrhd_pkg::KIND_VALUE;
				ev_res.position = pos_rdata;
				ev_res.value = sorted_rdata;
			end
			svrhd_pkg::SQ_VAL_DONE: begin
				ev_emit = 1'b1;
				ev_res.kind = svrhd_pkg::KIND_DONE;
			end
			svrhd_pkg::SQ_END: begin
				if (final_q && phase_q != svrhd_pkg::PH_IDLE) begin
					ev_emit = 1'b1;
					ev_res.err = svrhd_pkg::ERR_TRUNCATED;
				end
			end
			default: ;
		endcase
	end

	// hold the whole sequencer while a result is due but the output cannot take it
	assign go = !(pend_valid_q && !out_free
		&& (ev_emit || seq_q == svrhd_pkg::SQ_FLUSH));

	// next state
	always_comb begin
		seq_d = seq_q;
		phase_d = phase_q;
		bit_idx_d = bit_idx_q;
		byte_d = byte_q;
		final_d = final_q;
		field_cnt_d = field_cnt_q;
		field_d = field_q;
		total_d = total_q;
		min_d = min_q;
		max_d = max_q;
		asize_d = asize_q;
		item_d = item_q;
		rice_d = rice_q;
		cur_d = cur_q;
		quot_d = quot_q;
		acc_d = acc_q;
		clen_d = clen_q;
		tlen_d = tlen_q;
		tnext_d = tnext_q;
		tbase_d = tbase_q;
		sort_i_d = sort_i_q;
		pend_valid_d = pend_valid_q;
		pend_d = pend_q;
		lcount_d = lcount_q;
		fcode_d = fcode_q;
		base_d = base_q;
		fill_d = fill_q;

		if (go) begin
			if (ev_emit) begin
				pend_d = ev_res;
				pend_valid_d = 1'b1;
			end
			case (seq_q)
				svrhd_pkg::SQ_WAIT: begin
					if (in_valid) begin
						byte_d = stream_byte;
						final_d = final_byte;
						bit_idx_d = 3'd7;
						seq_d = svrhd_pkg::SQ_BIT;
					end
				end
				svrhd_pkg::SQ_BIT: begin
					seq_d = svrhd_pkg::SQ_NEXT;
					field_d = nfield;
					field_cnt_d = ncnt;
					case (phase_q)
						svrhd_pkg::PH_COUNT: begin
							if (ncnt >= svrhd_pkg::COUNT_BITS) begin
								total_d = nfield[15:0];
								field_d = '0;
								field_cnt_d = '0;
								phase_d = ev_emit ? svrhd_pkg::PH_IDLE : svrhd_pkg::PH_MIN;
							end
						end
						svrhd_pkg::PH_MIN: begin
							if (ncnt >= svrhd_pkg::SYMBOL_BITS) begin
								min_d = nfield[7:0] ^ svrhd_pkg::SYMBOL_BIAS;
								field_d = '0;
								field_cnt_d = '0;
								phase_d = svrhd_pkg::PH_MAX;
							end
						end
						svrhd_pkg::PH_MAX: begin
							if (ncnt >= svrhd_pkg::SYMBOL_BITS) begin
								max_d = nfield[7:0] ^ svrhd_pkg::SYMBOL_BIAS;
								item_d = '0;
								asize_d = '0;
								phase_d = ev_emit ? svrhd_pkg::PH_IDLE
									: svrhd_pkg::PH_PRESENT;
							end
						end
						svrhd_pkg::PH_PRESENT: begin
							asize_d = asize_new;
							if (present_end) begin
								item_d = '0;
								field_d = '0;
								field_cnt_d = '0;
								phase_d = ev_emit ? svrhd_pkg::PH_IDLE
									: svrhd_pkg::PH_LENGTHS;
							end else begin
								item_d = item_inc;
							end
						end
						svrhd_pkg::PH_LENGTHS: begin
							if (ncnt >= svrhd_pkg::LENGTH_BITS) begin
								lcount_d[tbl_idx] = lc_sel + 9'd1;
								item_d = item_inc;
								field_d = '0;
								field_cnt_d = '0;
								if (item_inc >= {4'd0, asize_q}) begin
									tlen_d = 5'd1;
									tnext_d = '0;
									tbase_d = '0;
									seq_d = svrhd_pkg::SQ_FC;
								end
							end
						end
						svrhd_pkg::PH_RICE: begin
							if (ncnt >= svrhd_pkg::RICE_BITS) begin
								rice_d = nfield[2:0];
								field_d = '0;
								field_cnt_d = '0;
								phase_d = svrhd_pkg::PH_FIRST;
							end
						end
						svrhd_pkg::PH_FIRST: begin
							if (first_done) begin
								if (first_bad) begin
									phase_d = svrhd_pkg::PH_IDLE;
								end else begin
									cur_d = {5'd0, nfield[10:0]};
									item_d = 13'd1;
									if (total_q <= 16'd1) begin
										phase_d = svrhd_pkg::PH_VALUES;
										item_d = '0;
										acc_d = '0;
										clen_d = '0;
									end else begin
										phase_d = svrhd_pkg::PH_UNARY;
										quot_d = '0;
									end
								end
							end
						end
						svrhd_pkg::PH_UNARY, svrhd_pkg::PH_REMAINDER: begin
							if (phase_q == svrhd_pkg::PH_UNARY && bit_in) begin
								quot_d = quot_inc;
								if (ev_emit) begin
									phase_d = svrhd_pkg::PH_IDLE;
								end
							end else if (phase_q == svrhd_pkg::PH_UNARY && rice_q != 3'd0) begin
								field_d = '0;
								field_cnt_d = '0;
								phase_d = svrhd_pkg::PH_REMAINDER;
							end else if (gap_finish) begin
								if (gap_bad) begin
									phase_d = svrhd_pkg::PH_IDLE;
								end else begin
									cur_d = gap_next[15:0];
									item_d = item_inc;
									if ({3'd0, item_inc} >= total_q) begin
										phase_d = svrhd_pkg::PH_VALUES;
										item_d = '0;
										acc_d = '0;
										clen_d = '0;
									end else begin
										phase_d = svrhd_pkg::PH_UNARY;
										quot_d = '0;
									end
								end
							end
						end
						svrhd_pkg::PH_VALUES: begin
							acc_d = nacc;
							clen_d = nlen;
							if (code_hit) begin
								seq_d = svrhd_pkg::SQ_VAL_EMIT;
							end else if (ev_emit) begin
								phase_d = svrhd_pkg::PH_IDLE;
							end
						end
						default: seq_d = svrhd_pkg::SQ_END;
					endcase
				end
				svrhd_pkg::SQ_NEXT: begin
					if (phase_q == svrhd_pkg::PH_IDLE || bit_idx_q == 3'd0) begin
						seq_d = svrhd_pkg::SQ_END;
					end else begin
						bit_idx_d = bit_idx_q - 3'd1;
						seq_d = svrhd_pkg::SQ_BIT;
					end
				end
				svrhd_pkg::SQ_FC: begin
					fcode_d[tbl_idx] = tnext_q;
					base_d[tbl_idx] = tbase_q;
					fill_d[tbl_idx] = '0;
					tnext_d = (tnext_q + {23'd0, lc_sel}) << 1;
					tbase_d = tbase_q + lc_sel;
					tlen_d = tlen_q + 5'd1;
					if (tlen_q == 5'(svrhd_pkg::LEN_SLOTS - 1)) begin
						sort_i_d = '0;
						seq_d = svrhd_pkg::SQ_SORT_RD;
					end
				end
				svrhd_pkg::SQ_SORT_RD: seq_d = svrhd_pkg::SQ_SORT_WR;
				svrhd_pkg::SQ_SORT_WR: begin
					if (len_rdata != 5'd0) begin
						fill_d[tbl_idx] = fill_sel + 9'd1;
					end
					sort_i_d = sort_i_q + 9'd1;
					if (sort_i_d >= asize_q) begin
						field_d = '0;
						field_cnt_d = '0;
						phase_d = svrhd_pkg::PH_RICE;
						seq_d = svrhd_pkg::SQ_NEXT;
					end else begin
						seq_d = svrhd_pkg::SQ_SORT_RD;
					end
				end
				svrhd_pkg::SQ_VAL_EMIT: begin
					item_d = item_inc;
					acc_d = '0;
					clen_d = '0;
					seq_d = ({3'd0, item_inc} >= total_q) ? svrhd_pkg::SQ_VAL_DONE
						: svrhd_pkg::SQ_NEXT;
				end
				svrhd_pkg::SQ_VAL_DONE: begin
					phase_d = svrhd_pkg::PH_IDLE;
					seq_d = svrhd_pkg::SQ_END;
				end
				svrhd_pkg::SQ_END: begin
					if (final_q) begin
						// open a fresh block
						phase_d = svrhd_pkg::PH_COUNT;
						field_d = '0;
						field_cnt_d = '0;
						total_d = '0;
						min_d = '0;
						max_d = '0;
						asize_d = '0;
						rice_d = '0;
						cur_d = '0;
						item_d = '0;
						quot_d = '0;
						acc_d = '0;
						clen_d = '0;
						for (int i = 0; i < svrhd_pkg::LEN_SLOTS; i++) begin
							lcount_d[i] = '0;
						end
					end
					seq_d = svrhd_pkg::SQ_FLUSH;
				end
				svrhd_pkg::SQ_FLUSH: begin
					pend_valid_d = 1'b0;
					seq_d = svrhd_pkg::SQ_WAIT;
				end
				default: seq_d = svrhd_pkg::SQ_WAIT;
			endcase
		end
	end

	// outputs
	always_comb begin
		in_stall = (seq_q != svrhd_pkg::SQ_WAIT);
		res_push = go && pend_valid_q && (ev_emit || seq_q == svrhd_pkg::SQ_FLUSH);
		res = pend_q;
		res.last = (seq_q == svrhd_pkg::SQ_FLUSH);

		alpha_we = go && seq_q == svrhd_pkg::SQ_BIT && phase_q == svrhd_pkg::PH_PRESENT
			&& bit_in;
		alpha_waddr = asize_q[7:0];
		alpha_wdata = min_q + item_q[7:0];
		len_we = go && seq_q == svrhd_pkg::SQ_BIT && phase_q == svrhd_pkg::PH_LENGTHS
			&& ncnt >= svrhd_pkg::LENGTH_BITS;
		len_waddr = item_q[7:0];
		alpha_re = (seq_q == svrhd_pkg::SQ_SORT_RD);
		sort_raddr = sort_i_q[7:0];

		sorted_we = (seq_q == svrhd_pkg::SQ_SORT_WR) && len_rdata != 5'd0;
		sorted_waddr = base_sel[7:0] + fill_sel[7:0];

		sorted_re = go && seq_q == svrhd_pkg::SQ_BIT && phase_q == svrhd_pkg::PH_VALUES
			&& code_hit;
		sorted_raddr = code_idx[7:0];
		pos_re = sorted_re;
		pos_raddr = item_q[svrhd_pkg::POS_AW-1:0];

		pos_we = 1'b0;
		pos_waddr = item_q[svrhd_pkg::POS_AW-1:0];
		pos_wdata = gap_next[15:0];
		if (go && seq_q == svrhd_pkg::SQ_BIT) begin
			if (phase_q == svrhd_pkg::PH_FIRST) begin
				pos_we = first_done && !first_bad;
				pos_waddr = '0;
				pos_wdata = {5'd0, nfield[10:0]};
			end else if (phase_q == svrhd_pkg::PH_UNARY
				|| phase_q == svrhd_pkg::PH_REMAINDER) begin
				pos_we = gap_finish && !gap_bad;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= svrhd_pkg::SQ_WAIT;
			phase_q <= svrhd_pkg::PH_COUNT;
			bit_idx_q <= '0;
			final_q <= 1'b0;
			field_cnt_q <= '0;
			field_q <= '0;
			total_q <= '0;
			min_q <= '0;
			max_q <= '0;
			asize_q <= '0;
			item_q <= '0;
			rice_q <= '0;
			cur_q <= '0;
			quot_q <= '0;
			acc_q <= '0;
			clen_q <= '0;
			tlen_q <= '0;
			sort_i_q <= '0;
			pend_valid_q <= 1'b0;
			for (int i = 0; i < svrhd_pkg::LEN_SLOTS; i++) begin
				lcount_q[i] <= '0;
			end
		end else begin
			seq_q <= seq_d;
			phase_q <= phase_d;
			bit_idx_q <= bit_idx_d;
			final_q <= final_d;
			field_cnt_q <= field_cnt_d;
			field_q <= field_d;
			total_q <= total_d;
			min_q <= min_d;
			max_q <= max_d;
			asize_q <= asize_d;
			item_q <= item_d;
			rice_q <= rice_d;
			cur_q <= cur_d;
			quot_q <= quot_d;
			acc_q <= acc_d;
			clen_q <= clen_d;
			tlen_q <= tlen_d;
			sort_i_q <= sort_i_d;
			pend_valid_q <= pend_valid_d;
			lcount_q <= lcount_d;
		end
	end

	always_ff @(posedge clk) begin
		byte_q <= byte_d;
		tnext_q <= tnext_d;
		tbase_q <= tbase_d;
		pend_q <= pend_d;
		fcode_q <= fcode_d;
		base_q <= base_d;
		fill_q <= fill_d;
	end

	svrhd_ram #(.WIDTH(8), .DEPTH(256)) u_alpha_ram (
		.clk(clk), .we(alpha_we), .waddr(alpha_waddr), .wdata(alpha_wdata),
		.re(alpha_re), .raddr(sort_raddr), .rdata(alpha_rdata)
	);

	svrhd_ram #(.WIDTH(5), .DEPTH(256)) u_len_ram (
		.clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_new),
		.re(alpha_re), .raddr(sort_raddr), .rdata(len_rdata)
	);

	svrhd_ram #(.WIDTH(8), .DEPTH(256)) u_sorted_ram (
		.clk(clk), .we(sorted_we), .waddr(sorted_waddr), .wdata(alpha_rdata),
		.re(sorted_re), .raddr(sorted_raddr), .rdata(sorted_rdata)
	);

	svrhd_ram #(.WIDTH(16), .DEPTH(4096)) u_pos_ram (
		.clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
		.re(pos_re), .raddr(pos_raddr), .rdata(pos_rdata)
	);

endmodule

@@ src/sparse_vector_rice_huffman_decoder.sv @@
// Sparse int8 vector decoder: Rice-coded positions, canonical Huffman values.
// Input channel (in_valid / in_stall): one byte of the encoded block per
// transfer, final_byte set on the last byte of a block. Output channel
// (out_valid / out_stall): one result per transfer - a (position, value)
// entry, a done marker or an error code; last_result flags the last result
// caused by a byte. Zero entries are never sent, the consumer clears the
// vector. cfg_write_en / cfg_write_data set the vector length (reset 65535);
// write it only while the block is idle.
// Each byte is walked bit by bit by a small sequencer: accept, SQ_BIT and
// SQ_NEXT per bit, SQ_END and SQ_FLUSH to close the byte, an extra step per
// decoded value, fewer steps once the block has ended, plus once per block a
// table build (SQ_FC per code length, SQ_SORT_RD/WR per alphabet symbol).
// in_stall is high while a byte is in work; the last result of a byte sits
// in the output register by the time the next byte can be accepted. Results
// are staged in one pending register and one output register; when the
// receiver stalls and both are full the sequencer holds, so nothing is
// dropped. Reset returns the decoder to the start of a block with the vector
// length at its maximum; stores need no clearing pass.
module sparse_vector_rice_huffman_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  stream_byte,
	input  logic        final_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] entry_position,
	output logic signed [7:0] entry_value,
	output logic [1:0]  result_kind,
	output logic [2:0]  error_code,
	output logic        last_result,
	input  logic        cfg_write_en,
	input  logic [15:0] cfg_write_data
);

	logic [15:0]        dim_limit_q;
	logic               out_valid_q;
	svrhd_pkg::result_t out_q;
	logic               out_free;
	logic               res_push;
	svrhd_pkg::result_t res;

	assign out_free = !out_valid_q || !out_stall;

	svrhd_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stream_byte(stream_byte),
		.final_byte(final_byte),
		.dim_limit(dim_limit_q),
		.out_free(out_free),
		.res_push(res_push),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_limit_q <= 16'hFFFF;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				dim_limit_q <= cfg_write_data;
			end
			// load on push, drop once the transfer completes
			if (res_push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign entry_position = out_q.position;
	assign entry_value = out_q.value;
	assign result_kind = out_q.kind;
	assign error_code = out_q.err;
	assign last_result = out_q.last;

endmodule

@@ tb/sparse_vector_rice_huffman_decoder_tb.sv @@
module sparse_vector_rice_huffman_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [7:0] b;
		bit fin;
		bit typed;
		logic [1:0] kind;
		logic [2:0] err;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] stream_byte = 8'd0;
	logic final_byte = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [15:0] entry_position;
	logic signed [7:0] entry_value;
	logic [1:0] result_kind;
	logic [2:0] error_code;
	logic last_result;
	logic cfg_write_en = 1'b0;
	logic [15:0] cfg_write_data = 16'd0;

	sparse_vector_rice_huffman_decoder i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.stream_byte(stream_byte), .final_byte(final_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.entry_position(entry_position), .entry_value(entry_value),
		.result_kind(result_kind), .error_code(error_code),
		.last_result(last_result),
		.cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	stim_t byte_q[$];
	stim_t cur_byte;
	svrhd_pkg::result_t expected_results[$];
	svrhd_pkg::result_t byte_results[$];
	int fail_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// decoder mirror
	logic [15:0] vec_limit = 16'hFFFF;
	svrhd_pkg::phase_t dph;
	logic [5:0] fbits;
	logic [31:0] fshift;
	logic [15:0] n_total, a_size, idx, quot;
	logic [7:0] min_f, max_f, rice_k;
	logic [7:0] alpha_syms [256];
	logic [4:0] sym_lens [256];
	logic [7:0] sorted_syms [256];
	logic [15:0] len_counts [32];
	logic [31:0] first_code [32];
	logic [15:0] len_base [32];
	logic [31:0] cur_pos;
	logic [15:0] pos_store [4096];
	logic [31:0] code_acc;
	logic [5:0] code_bits;

	task automatic put_result(logic [15:0] p, logic [7:0] v, logic [1:0] k,
			logic [2:0] e);
		svrhd_pkg::result_t r;
		r.position = p; r.value = v; r.kind = k; r.err = e; r.last = 1'b0;
		if (byte_results.size() < 9)
			byte_results.push_back(r);
	endtask

	task automatic abort_block(logic [2:0] e);
		put_result(16'd0, 8'd0, svrhd_pkg::KIND_ERROR, e);
		dph = svrhd_pkg::PH_IDLE;
	endtask

	task automatic close_block();
		put_result(16'd0, 8'd0, svrhd_pkg::KIND_DONE, svrhd_pkg::ERR_NONE);
		dph = svrhd_pkg::PH_IDLE;
	endtask

	task automatic open_field(svrhd_pkg::phase_t p);
		dph = p;
		fbits = 0;
		fshift = 0;
	endtask

	function automatic bit shift_in(bit b, int w);
		fshift = {fshift[30:0], b};
		fbits++;
		return fbits >= w;
	endfunction

	task automatic clear_block();
		open_field(svrhd_pkg::PH_COUNT);
		n_total = 0; min_f = 0; max_f = 0; a_size = 0;
		for (int i = 0; i < 32; i++) len_counts[i[4:0]] = 0;
		rice_k = 0; cur_pos = 0; idx = 0; quot = 0; code_acc = 0; code_bits = 0;
	endtask

	task automatic build_code_tables();
		logic [31:0] nxt, base, k;
		nxt = 0; base = 0; k = 0;
		first_code[0] = 0;
		len_base[0] = 0;
		for (int l = 1; l < 32; l++) begin
			first_code[l[4:0]] = nxt;
			len_base[l[4:0]] = base[15:0];
			nxt += {16'd0, len_counts[l[4:0]]};
			base += {16'd0, len_counts[l[4:0]]};
			nxt <<= 1;
		end
		for (int l = 1; l < 32; l++)
			for (int i = 0; i < a_size && i < 256; i++)
				if (sym_lens[i[7:0]] == l && k < 256) begin
					sorted_syms[k[7:0]] = alpha_syms[i[7:0]];
					k++;
				end
	endtask

	task automatic enter_values();
		dph = svrhd_pkg::PH_VALUES;
		idx = 0; code_acc = 0; code_bits = 0;
	endtask

	task automatic store_gap(logic [31:0] rem);
		logic [31:0] step, nxt;
		step = ({16'd0, quot} << rice_k[2:0]) | rem;
		nxt = cur_pos + step + 1;
		if (nxt >= vec_limit || idx >= svrhd_pkg::MAX_ENTRIES) begin
			abort_block(svrhd_pkg::ERR_POS_RANGE);
		end else begin
			pos_store[idx[11:0]] = nxt[15:0];
			cur_pos = nxt;
			idx++;
			if (idx >= n_total) enter_values();
			else begin
				dph = svrhd_pkg::PH_UNARY;
				quot = 0;
			end
		end
	endtask

	task automatic decode_bit(bit b);
		int lo, hi;
		logic [31:0] off, sidx;
		logic [15:0] where;
		logic [7:0] val;
		case (dph)
			svrhd_pkg::PH_COUNT: if (shift_in(b, 16)) begin
				n_total = fshift[15:0];
				if (n_total > svrhd_pkg::MAX_ENTRIES) abort_block(svrhd_pkg::ERR_TOO_MANY);
				else open_field(svrhd_pkg::PH_MIN);
			end
			svrhd_pkg::PH_MIN: if (shift_in(b, 8)) begin
				min_f = fshift[7:0] ^ svrhd_pkg::SYMBOL_BIAS;
				open_field(svrhd_pkg::PH_MAX);
			end
			svrhd_pkg::PH_MAX: if (shift_in(b, 8)) begin
				max_f = fshift[7:0] ^ svrhd_pkg::SYMBOL_BIAS;
				lo = {24'd0, min_f ^ svrhd_pkg::SYMBOL_BIAS};
				hi = {24'd0, max_f ^ svrhd_pkg::SYMBOL_BIAS};
				if (n_total == 0) close_block();
				else if (hi < lo) abort_block(svrhd_pkg::ERR_EMPTY_ALPHABET);
				else begin
					dph = svrhd_pkg::PH_PRESENT;
					idx = 0;
					a_size = 0;
				end
			end
			svrhd_pkg::PH_PRESENT: begin
				lo = {24'd0, min_f ^ svrhd_pkg::SYMBOL_BIAS};
				hi = {24'd0, max_f ^ svrhd_pkg::SYMBOL_BIAS};
				if (b) begin
					if (a_size < 256) alpha_syms[a_size[7:0]] = min_f + idx[7:0];
					if (a_size < 511) a_size++;
				end
				if (idx >= hi - lo) begin
					if (a_size == 0 || a_size > 256)
						abort_block(svrhd_pkg::ERR_EMPTY_ALPHABET);
					else begin
						open_field(svrhd_pkg::PH_LENGTHS);
						idx = 0;
					end
				end else
					idx++;
			end
			svrhd_pkg::PH_LENGTHS: if (shift_in(b, 5)) begin
				if (idx < 256) sym_lens[idx[7:0]] = fshift[4:0];
				len_counts[fshift[4:0]]++;
				idx++;
				fbits = 0;
				fshift = 0;
				if (idx >= a_size) begin
					build_code_tables();
					open_field(svrhd_pkg::PH_RICE);
				end
			end
			svrhd_pkg::PH_RICE: if (shift_in(b, 3)) begin
				rice_k = {5'd0, fshift[2:0]};
				open_field(svrhd_pkg::PH_FIRST);
			end
			svrhd_pkg::PH_FIRST: if (shift_in(b, 11)) begin
				if (fshift >= vec_limit) abort_block(svrhd_pkg::ERR_POS_RANGE);
				else begin
					pos_store[0] = fshift[15:0];
					cur_pos = fshift;
					idx = 1;
					if (n_total <= 1) enter_values();
					else begin
						dph = svrhd_pkg::PH_UNARY;
						quot = 0;
					end
				end
			end
			svrhd_pkg::PH_UNARY: begin
				if (b) begin
					quot++;
					if (quot > svrhd_pkg::QUOTIENT_CAP)
						abort_block(svrhd_pkg::ERR_RICE_RUNAWAY);
				end else if (rice_k == 0) store_gap(0);
				else open_field(svrhd_pkg::PH_REMAINDER);
			end
			svrhd_pkg::PH_REMAINDER: if (shift_in(b, rice_k)) store_gap(fshift);
			svrhd_pkg::PH_VALUES: begin
				code_acc = {code_acc[30:0], b};
				code_bits++;
				if (code_bits < 32 && len_counts[code_bits[4:0]] != 0) begin
					off = code_acc - first_code[code_bits[4:0]];
					if (off < len_counts[code_bits[4:0]]) begin
						sidx = {16'd0, len_base[code_bits[4:0]]} + off;
						where = idx < svrhd_pkg::MAX_ENTRIES ? pos_store[idx[11:0]] : 16'd0;
						val = sidx < 256 ? sorted_syms[sidx[7:0]] : 8'd0;
						put_result(where, val, svrhd_pkg::KIND_VALUE, svrhd_pkg::ERR_NONE);
						idx++;
						code_acc = 0;
						code_bits = 0;
						if (idx >= n_total) close_block();
						return;
					end
				end
				if (code_bits >= svrhd_pkg::MAX_CODE_LENGTH)
					abort_block(svrhd_pkg::ERR_BAD_CODE);
			end
			default: ;
		endcase
	endtask

	task automatic decode_byte(stim_t s);
		byte_results.delete();
		for (int i = 7; i >= 0; i--) decode_bit(s.b[i[2:0]]);
		if (s.fin) begin
			if (dph != svrhd_pkg::PH_IDLE) abort_block(svrhd_pkg::ERR_TRUNCATED);
			clear_block();
		end
		if (s.typed) begin
			byte_results.delete();
			put_result(16'd0, 8'd0, s.kind, s.err);
		end
		if (byte_results.size() > 0) byte_results[$].last = 1'b1;
		foreach (byte_results[i]) expected_results.push_back(byte_results[i]);
	endtask

	// input side: hold the payload until transfer, idle at random
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) decode_byte(cur_byte);
		if (!in_valid || !in_stall) begin
			if (arst_n && byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				cur_byte <= byte_q[0];
				stream_byte <= byte_q[0].b;
				final_byte <= byte_q[0].fin;
				in_valid <= 1'b1;
				void'(byte_q.pop_front());
			end else
				in_valid <= 1'b0;
		end
	end

	// output side: check each transfer against the oldest expectation
	always @(posedge clk) begin
		svrhd_pkg::result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result pos=%0d val=%0d kind=%0d err=%0d last=%0d",
					$time, entry_position, entry_value, result_kind, error_code, last_result);
				fail_count++;
			end else begin
				e = expected_results.pop_front();
				if (entry_position !== e.position || entry_value !== e.value ||
						result_kind !== e.kind || error_code !== e.err ||
						last_result !== e.last) begin
					$display("%0t: expected pos=%0d val=%0d kind=%0d err=%0d last=%0d",
						$time, e.position, $signed(e.value), e.kind, e.err, e.last);
					$display("%0t: actual   pos=%0d val=%0d kind=%0d err=%0d last=%0d",
						$time, entry_position, entry_value, result_kind, error_code,
						last_result);
					fail_count++;
				end
			end
		end
		out_stall <= $urandom_range(99) < recv_stall_pct;
	end

	task automatic push_byte(logic [7:0] b, bit fin);
		stim_t s;
		s.b = b; s.fin = fin; s.typed = 0;
		s.kind = svrhd_pkg::KIND_VALUE; s.err = svrhd_pkg::ERR_NONE;
		byte_q.push_back(s);
	endtask

	bit enc_bits[$];

	task automatic put_bits(int v, int w);
		for (int i = w - 1; i >= 0; i--) enc_bits.push_back(1'((v >> i) & 1));
	endtask

	// encode one block; mode 0 clean, 1 truncated, 2 flipped bit, 3 bad code,
	// 4 runaway quotient
	task automatic encode_block(int mode);
		int n, lo, span, k, L, rk, lim, g, nb, cut;
		bit pres [8];
		logic [7:0] b;
		enc_bits.delete();
		n = $urandom_range(1, 8);
		put_bits(n, 16);
		lo = $urandom_range(0, 250);
		span = $urandom_range(0, 5);
		put_bits(lo, 8);
		put_bits(lo + span, 8);
		k = 0;
		for (int i = 0; i <= span; i++) begin
			pres[i] = 1'($urandom_range(0, 1));
			k += pres[i];
		end
		if (k == 0) begin
			pres[$urandom_range(0, span)] = 1;
			k = 1;
		end
		for (int i = 0; i <= span; i++) put_bits(pres[i], 1);
		L = 1;
		while ((1 << L) < k) L++;
		if (mode == 3) L = 5;
		repeat (k) put_bits(L, 5);
		rk = $urandom_range(0, 7);
		put_bits(rk, 3);
		lim = vec_limit > 2048 ? 2048 : vec_limit;
		put_bits($urandom_range(0, lim - 1), 11);
		for (int i = 1; i < n; i++) begin
			if (mode == 4) begin
				repeat (2001) enc_bits.push_back(1);
				break;
			end
			g = $urandom_range(0, 12);
			repeat (g >> rk) enc_bits.push_back(1);
			enc_bits.push_back(0);
			if (rk != 0) put_bits(g & ((1 << rk) - 1), rk);
		end
		if (mode == 3) repeat (32) enc_bits.push_back(1);
		else for (int i = 0; i < n; i++) put_bits($urandom_range(0, k - 1), L);
		if (mode == 2) begin
			g = $urandom_range(0, enc_bits.size() - 1);
			enc_bits[g] = !enc_bits[g];
		end
		while (enc_bits.size() % 8 != 0) enc_bits.push_back(1'($urandom_range(0, 1)));
		if ($urandom_range(0, 3) == 0) put_bits($urandom_range(0, 255), 8);
		nb = enc_bits.size() / 8;
		cut = mode == 1 ? $urandom_range(1, nb - 1) : nb;
		for (int i = 0; i < cut; i++) begin
			for (int j = 0; j < 8; j++) b[7 - j] = enc_bits[i * 8 + j];
			push_byte(b, i == cut - 1);
		end
	endtask

	task automatic wait_idle();
		while (byte_q.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic write_limit(logic [15:0] v);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_write_data <= v;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		vec_limit = v;
	endtask

	stim_t directed [] = '{
		'{8'h00, 0, 0, svrhd_pkg::KIND_VALUE, svrhd_pkg::ERR_NONE},
		'{8'h00, 0, 0, svrhd_pkg::KIND_VALUE, svrhd_pkg::ERR_NONE},
		'{8'h80, 0, 0, svrhd_pkg::KIND_VALUE, svrhd_pkg::ERR_NONE},
		'{8'h80, 1, 1, svrhd_pkg::KIND_DONE, svrhd_pkg::ERR_NONE},
		'{8'h10, 0, 0, svrhd_pkg::KIND_VALUE, svrhd_pkg::ERR_NONE},
		'{8'h01, 1, 1, svrhd_pkg::KIND_ERROR, svrhd_pkg::ERR_TOO_MANY},
		'{8'hFF, 0, 0, svrhd_pkg::KIND_VALUE, svrhd_pkg::ERR_NONE},
		'{8'hFF, 1, 1, svrhd_pkg::KIND_ERROR, svrhd_pkg::ERR_TOO_MANY},
		'{8'h00, 0, 0, svrhd_pkg::KIND_VALUE, svrhd_pkg::ERR_NONE},
		'{8'h01, 0, 0, svrhd_pkg::KIND_VALUE, svrhd_pkg::ERR_NONE},
		'{8'h81, 0, 0, svrhd_pkg::KIND_VALUE, svrhd_pkg::ERR_NONE},
		'{8'h80, 1, 1, svrhd_pkg::KIND_ERROR, svrhd_pkg::ERR_EMPTY_ALPHABET},
		'{8'h00, 0, 0, svrhd_pkg::KIND_VALUE, svrhd_pkg::ERR_NONE},
		'{8'h01, 1, 1, svrhd_pkg::KIND_ERROR, svrhd_pkg::ERR_TRUNCATED},
		'{8'h00, 0, 0, svrhd_pkg::KIND_VALUE, svrhd_pkg::ERR_NONE},
		'{8'h01, 0, 0, svrhd_pkg::KIND_VALUE, svrhd_pkg::ERR_NONE},
		'{8'h80, 0, 0, svrhd_pkg::KIND_VALUE, svrhd_pkg::ERR_NONE},
		'{8'h80, 0, 0, svrhd_pkg::KIND_VALUE, svrhd_pkg::ERR_NONE},
		'{8'h00, 1, 1, svrhd_pkg::KIND_ERROR, svrhd_pkg::ERR_EMPTY_ALPHABET},
		// one entry, symbol 5 at position 3, then done
		'{8'h00, 0, 0, svrhd_pkg::KIND_VALUE, svrhd_pkg::ERR_NONE},
		'{8'h01, 0, 0, svrhd_pkg::KIND_VALUE, svrhd_pkg::ERR_NONE},
		'{8'h85, 0, 0, svrhd_pkg::KIND_VALUE, svrhd_pkg::ERR_NONE},
		'{8'h85, 0, 0, svrhd_pkg::KIND_VALUE, svrhd_pkg::ERR_NONE},
		'{8'h84, 0, 0, svrhd_pkg::KIND_VALUE, svrhd_pkg::ERR_NONE},
		'{8'h00, 0, 0, svrhd_pkg::KIND_VALUE, svrhd_pkg::ERR_NONE},
		'{8'h30, 1, 0, svrhd_pkg::KIND_VALUE, svrhd_pkg::ERR_NONE}
	};

	int limits [5] = '{65535, 1, 300, 2048, 0};
	int send_pcts [5] = '{0, 47, 0, 34, 47};
	int recv_pcts [5] = '{0, 0, 47, 34, 0};

	initial begin
		int sent, r;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		wait_idle();
		write_limit(16'hFFFF);
		foreach (directed[i]) byte_q.push_back(directed[i]);
		encode_block(3);
		wait_idle();
		for (int p = 0; p < 5; p++) begin
			write_limit(p == 4 ? 16'($urandom_range(2, 65534)) : 16'(limits[p]));
			send_idle_pct = send_pcts[p];
			recv_stall_pct = recv_pcts[p];
			sent = 0;
			while (sent < 32) begin
				r = $urandom_range(0, 99);
				sent -= byte_q.size();
				if (r < 60) encode_block(0);
				else if (r < 70) encode_block(1);
				else if (r < 80) encode_block(2);
				else if (r < 88) encode_block(3);
				else begin
					repeat ($urandom_range(0, 5)) push_byte(8'($urandom_range(0, 255)), 0);
					push_byte(8'($urandom_range(0, 255)), 1);
				end
				sent += byte_q.size();
				// drop in unthrottled stretches
				if (p > 0 && $urandom_range(0, 3) == 0) begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end else begin
					send_idle_pct = send_pcts[p];
					recv_stall_pct = recv_pcts[p];
				end
			end
			wait_idle();
		end
		if (fail_count == 0 && expected_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#5ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
